@@ src/tdc_pkg.sv @@
// Shared types and constants for the thermostat dead-band controller.
`timescale 1ns / 1ps
`default_nettype none

package tdc_pkg;

    localparam int CODE_W     = 10;
    localparam int EXT_T_W    = 13;
    localparam int INT_T_W    = 15;
    localparam int SETPOINT_W = 6;
    localparam int GAIN_W     = 24;
    localparam int OFFSET_W   = 31;
    localparam int BAND_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [GAIN_W-1:0]     GAIN_RESET   = 24'd951352;
    localparam logic [OFFSET_W-1:0]   OFFSET_RESET = 31'd306472878;
    localparam logic [BAND_W-1:0]     BAND_RESET   = 8'd5;

    localparam logic [SETPOINT_W-1:0] SETPOINT_MIN   = 6'd10;
    localparam logic [SETPOINT_W-1:0] SETPOINT_MAX   = 6'd35;
    localparam logic [SETPOINT_W-1:0] SETPOINT_RESET = 6'd23;

    // External scale: tenths = (code * 625) >> 7
    localparam logic [9:0] EXT_SCALE = 10'd625;
    localparam int         EXT_SHIFT = 7;

    localparam logic signed [INT_T_W-1:0] INT_TENTHS_MIN = -15'sd8192;
    localparam logic signed [INT_T_W-1:0] INT_TENTHS_MAX = 15'sd16383;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN      = 2'd0,
        CFG_OFFSET    = 2'd1,
        CFG_HALF_BAND = 2'd2
    } cfg_idx_t;

    // Converted temperatures plus this tick's buttons
    typedef struct packed {
        logic [EXT_T_W-1:0]        ext_tenths;
        logic signed [INT_T_W-1:0] int_tenths;
        logic                      up;
        logic                      down;
        logic                      mode;
    } conv_t;

endpackage

`default_nettype wire

@@ src/tdc_conv.sv @@
// Input register and sensor conversion stage.
`timescale 1ns / 1ps
`default_nettype none

module tdc_conv (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [tdc_pkg::CODE_W-1:0]    s_external_code,
    input  wire logic [tdc_pkg::CODE_W-1:0]    s_internal_code,
    input  wire logic                          s_button_up,
    input  wire logic                          s_button_down,
    input  wire logic                          s_button_mode,
    input  wire logic [tdc_pkg::GAIN_W-1:0]    gain,
    input  wire logic [tdc_pkg::OFFSET_W-1:0]  offset,
    output logic                               conv_valid,
    input  wire logic                          conv_ready,
    output tdc_pkg::conv_t                     conv_item
);
    import tdc_pkg::*;

    logic                in_valid_reg;
    logic [CODE_W-1:0]   ext_code_reg;
    logic [CODE_W-1:0]   int_code_reg;
    logic                up_reg;
    logic                down_reg;
    logic                mode_reg;

    logic                cv_valid_reg;
    conv_t               cv_reg;
    conv_t               cv_next;
    logic                cv_ready;

    logic [19:0]         ext_prod;
    logic [33:0]         int_prod;
    logic signed [35:0]  int_diff;
    logic signed [35:0]  int_biased;
    logic signed [19:0]  int_trunc;

    assign cv_ready = !cv_valid_reg || conv_ready;
    assign s_ready  = !in_valid_reg || cv_ready;

    always_comb begin
        ext_prod   = 20'(ext_code_reg) * 20'(EXT_SCALE);
        int_prod   = 34'(int_code_reg) * 34'(gain);
        int_diff   = $signed({2'b00, int_prod}) - $signed({5'b00000, offset});
        // bias negative values so the arithmetic shift truncates toward zero
        int_biased = int_diff + $signed({20'd0, {16{int_diff[35]}}});
        int_trunc  = int_biased[35:16];

        cv_next.ext_tenths = ext_prod[EXT_SHIFT +: EXT_T_W];
        if (int_trunc < $signed(20'(INT_TENTHS_MIN))) begin
            cv_next.int_tenths = INT_TENTHS_MIN;
        end else if (int_trunc > $signed(20'(INT_TENTHS_MAX))) begin
            cv_next.int_tenths = INT_TENTHS_MAX;
        end else begin
            cv_next.int_tenths = int_trunc[INT_T_W-1:0];
        end
        cv_next.up   = up_reg;
        cv_next.down = down_reg;
        cv_next.mode = mode_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            ext_code_reg <= s_external_code;
            int_code_reg <= s_internal_code;
            up_reg       <= s_button_up;
            down_reg     <= s_button_down;
            mode_reg     <= s_button_mode;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_valid_reg <= 1'b0;
        end else if (cv_ready) begin
            cv_valid_reg <= in_valid_reg;
        end
        if (in_valid_reg && cv_ready) begin
            cv_reg <= cv_next;
        end
    end

    assign conv_valid = cv_valid_reg;
    assign conv_item  = cv_reg;

endmodule

`default_nettype wire

@@ src/tdc_ctrl.sv @@
// Setpoint, sensor select and dead-band furnace control with result register.
`timescale 1ns / 1ps
`default_nettype none

module tdc_ctrl (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 conv_valid,
    output logic                                      conv_ready,
    input  wire tdc_pkg::conv_t                       conv_item,
    input  wire logic [tdc_pkg::BAND_W-1:0]           half_band,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic                                      m_furnace_on,
    output logic [tdc_pkg::EXT_T_W-1:0]               m_external_tenths,
    output logic signed [tdc_pkg::INT_T_W-1:0]        m_internal_tenths,
    output logic [tdc_pkg::SETPOINT_W-1:0]            m_setpoint_degrees,
    output logic                                      m_using_internal
);
    import tdc_pkg::*;

    logic                      res_valid_reg;
    logic [SETPOINT_W-1:0]     setpoint_reg;
    logic [SETPOINT_W-1:0]     setpoint_next;
    logic                      select_reg;
    logic                      select_next;
    logic                      furnace_reg;
    logic                      furnace_next;
    logic [EXT_T_W-1:0]        ext_reg;
    logic signed [INT_T_W-1:0] int_reg;

    logic [SETPOINT_W-1:0]     sp_up;
    logic [8:0]                sp10;
    logic signed [15:0]        sel_t;
    logic signed [15:0]        thr_lo;
    logic signed [15:0]        thr_hi;
    logic                      take;

    assign conv_ready = !res_valid_reg || m_ready;
    assign take       = conv_valid && conv_ready;

    always_comb begin
        // up first, then down, each wrapping at the ends of the range
        sp_up = setpoint_reg;
        if (conv_item.up) begin
            sp_up = (setpoint_reg >= SETPOINT_MAX) ? SETPOINT_MIN : setpoint_reg + 6'd1;
        end
        setpoint_next = sp_up;
        if (conv_item.down) begin
            setpoint_next = (sp_up <= SETPOINT_MIN) ? SETPOINT_MAX : sp_up - 6'd1;
        end
        select_next = select_reg ^ conv_item.mode;

        sp10   = {setpoint_next, 3'b000} + {2'b00, setpoint_next, 1'b0};
        sel_t  = select_next ? 16'(conv_item.int_tenths)
                             : $signed({3'b000, conv_item.ext_tenths});
        thr_lo = $signed({7'd0, sp10}) - $signed({8'd0, half_band});
        thr_hi = $signed({7'd0, sp10}) + $signed({8'd0, half_band});

        furnace_next = furnace_reg;
        if (sel_t < thr_lo) begin
            furnace_next = 1'b1;
        end
        if (sel_t > thr_hi) begin
            furnace_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
            setpoint_reg  <= SETPOINT_RESET;
            select_reg    <= 1'b0;
            furnace_reg   <= 1'b0;
        end else begin
            if (conv_ready) begin
                res_valid_reg <= conv_valid;
            end
            if (take) begin
                setpoint_reg <= setpoint_next;
                select_reg   <= select_next;
                furnace_reg  <= furnace_next;
            end
        end
        if (take) begin
            ext_reg <= conv_item.ext_tenths;
            int_reg <= conv_item.int_tenths;
        end
    end

    // state registers double as the result fields: they change only on take
    assign m_valid            = res_valid_reg;
    assign m_furnace_on       = furnace_reg;
    assign m_external_tenths  = ext_reg;
    assign m_internal_tenths  = int_reg;
    assign m_setpoint_degrees = setpoint_reg;
    assign m_using_internal   = select_reg;

endmodule

`default_nettype wire

@@ src/thermostat_deadband_controller.sv @@
// Top level of the thermostat dead-band controller.
//
// Each input item is one refresh tick: two 10-bit converter codes and the
// up, down and mode button flags. Each item yields exactly one result item
// with the furnace drive, both temperatures in tenths of a degree, the
// setpoint and the selected sensor, all as they stand after that tick.
// Path: an accepted item passes the input register, the conversion
// register and the control/result register. Throughput: one item per
// cycle while m_ready is high; the three register stages hold one item each.
// Stall: when m_ready is low the result holds and the stages behind it
// fill; s_ready drops only once all three stages are full.
// Config: write gain, offset and half band through cfg_valid/cfg_index/
// cfg_data while no item is in flight; cfg_ready is always high and an
// unknown index is dropped.
// Reset (aresetn low, synchronous): pipeline empties, setpoint 23,
// external sensor selected, furnace off, registers take their defaults.
`timescale 1ns / 1ps
`default_nettype none

module thermostat_deadband_controller (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [tdc_pkg::CODE_W-1:0]           s_external_code,
    input  wire logic [tdc_pkg::CODE_W-1:0]           s_internal_code,
    input  wire logic                                 s_button_up,
    input  wire logic                                 s_button_down,
    input  wire logic                                 s_button_mode,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic                                      m_furnace_on,
    output logic [tdc_pkg::EXT_T_W-1:0]               m_external_tenths,
    output logic signed [tdc_pkg::INT_T_W-1:0]        m_internal_tenths,
    output logic [tdc_pkg::SETPOINT_W-1:0]            m_setpoint_degrees,
    output logic                                      m_using_internal,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [tdc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [tdc_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import tdc_pkg::*;

    logic [GAIN_W-1:0]   gain_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [BAND_W-1:0]   band_reg;

    logic                conv_valid;
    logic                conv_ready;
    conv_t               conv_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= GAIN_RESET;
            offset_reg <= OFFSET_RESET;
            band_reg   <= BAND_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GAIN:      gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_OFFSET:    offset_reg <= cfg_data[OFFSET_W-1:0];
                CFG_HALF_BAND: band_reg   <= cfg_data[BAND_W-1:0];
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    tdc_conv u_conv (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_external_code (s_external_code),
        .s_internal_code (s_internal_code),
        .s_button_up     (s_button_up),
        .s_button_down   (s_button_down),
        .s_button_mode   (s_button_mode),
        .gain            (gain_reg),
        .offset          (offset_reg),
        .conv_valid      (conv_valid),
        .conv_ready      (conv_ready),
        .conv_item       (conv_item)
    );

    tdc_ctrl u_ctrl (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .conv_valid         (conv_valid),
        .conv_ready         (conv_ready),
        .conv_item          (conv_item),
        .half_band          (band_reg),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_furnace_on       (m_furnace_on),
        .m_external_tenths  (m_external_tenths),
        .m_internal_tenths  (m_internal_tenths),
        .m_setpoint_degrees (m_setpoint_degrees),
        .m_using_internal   (m_using_internal)
    );

endmodule

`default_nettype wire

@@ tb/tb_thermostat_deadband_controller.sv @@
// Self-checking testbench for the thermostat dead-band controller, with a tick-level predictor.
`timescale 1ns / 1ps

import tdc_pkg::*;

typedef struct packed {
    logic                        furnace_on;
    logic [EXT_T_W-1:0]          external_tenths;
    logic signed [INT_T_W-1:0]   internal_tenths;
    logic [SETPOINT_W-1:0]       setpoint_degrees;
    logic                        using_internal;
} tick_result_t;

class thermostat_scoreboard;
    logic [GAIN_W-1:0]     gain;
    logic [OFFSET_W-1:0]   offset;
    logic [BAND_W-1:0]     half_band;
    logic [SETPOINT_W-1:0] setpoint;
    logic                  use_internal;
    logic                  furnace;
    tick_result_t          expected_ticks[$];
    int                    errors;

    function new();
        gain         = GAIN_RESET;
        offset       = OFFSET_RESET;
        half_band    = BAND_RESET;
        setpoint     = SETPOINT_RESET;
        use_internal = 1'b0;
        furnace      = 1'b0;
        errors       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        case (index)
            CFG_GAIN:      gain = data[GAIN_W-1:0];
            CFG_OFFSET:    offset = data[OFFSET_W-1:0];
            CFG_HALF_BAND: half_band = data[BAND_W-1:0];
            default: ;
        endcase
    endfunction

    function void predict_tick(logic [CODE_W-1:0] ext_code, logic [CODE_W-1:0] int_code,
                               logic up, logic down, logic mode);
        tick_result_t r;
        longint       scaled;
        longint       diff;
        longint       t;
        int           selected;
        int           center;
        scaled = (longint'(ext_code) * 625) >>> 7;
        r.external_tenths = scaled[EXT_T_W-1:0];

        // Q16 difference, truncated toward zero, then saturated
        diff = longint'(int_code) * longint'(gain) - longint'(offset);
        t = (diff < 0) ? -((-diff) >>> 16) : (diff >>> 16);
        if (t < longint'(INT_TENTHS_MIN)) t = longint'(INT_TENTHS_MIN);
        if (t > longint'(INT_TENTHS_MAX)) t = longint'(INT_TENTHS_MAX);
        r.internal_tenths = t[INT_T_W-1:0];

        if (up)
            setpoint = (setpoint >= SETPOINT_MAX) ? SETPOINT_MIN : setpoint + SETPOINT_W'(1);
        if (down)
            setpoint = (setpoint <= SETPOINT_MIN) ? SETPOINT_MAX : setpoint - SETPOINT_W'(1);
        if (mode)
            use_internal = ~use_internal;

        selected = use_internal ? int'(r.internal_tenths) : int'(r.external_tenths);
        center = int'(setpoint) * 10;
        if (selected < center - int'(half_band)) furnace = 1'b1;
        if (selected > center + int'(half_band)) furnace = 1'b0;

        r.furnace_on       = furnace;
        r.setpoint_degrees = setpoint;
        r.using_internal   = use_internal;
        expected_ticks.push_back(r);
    endfunction

    function void check_tick(tick_result_t got);
        tick_result_t want;
        if (expected_ticks.size() == 0) begin
            $error("result item arrived with no tick waiting for it");
            errors++;
            return;
        end
        want = expected_ticks.pop_front();
        if (got.furnace_on !== want.furnace_on) begin
            $error("furnace_on: expected %0d, got %0d", want.furnace_on, got.furnace_on);
            errors++;
        end
        if (got.external_tenths !== want.external_tenths) begin
            $error("external_tenths: expected %0d, got %0d",
                   want.external_tenths, got.external_tenths);
            errors++;
        end
        if (got.internal_tenths !== want.internal_tenths) begin
            $error("internal_tenths: expected %0d, got %0d",
                   want.internal_tenths, got.internal_tenths);
            errors++;
        end
        if (got.setpoint_degrees !== want.setpoint_degrees) begin
            $error("setpoint_degrees: expected %0d, got %0d",
                   want.setpoint_degrees, got.setpoint_degrees);
            errors++;
        end
        if (got.using_internal !== want.using_internal) begin
            $error("using_internal: expected %0d, got %0d",
                   want.using_internal, got.using_internal);
            errors++;
        end
    endfunction

    function int pending();
        return expected_ticks.size();
    endfunction
endclass

module tb_thermostat_deadband_controller;

    localparam int                   CYCLE_LIMIT = 200000;
    localparam int                   HOLD_CYCLES = 60;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic [CODE_W-1:0]           s_external_code;
    logic [CODE_W-1:0]           s_internal_code;
    logic                        s_button_up;
    logic                        s_button_down;
    logic                        s_button_mode;
    logic                        m_valid;
    logic                        m_ready;
    logic                        m_furnace_on;
    logic [EXT_T_W-1:0]          m_external_tenths;
    logic signed [INT_T_W-1:0]   m_internal_tenths;
    logic [SETPOINT_W-1:0]       m_setpoint_degrees;
    logic                        m_using_internal;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;

    int unsigned          sender_idle_pct = 0;
    int unsigned          receiver_stall_pct = 0;
    int                   hold_requests = 0;
    int                   cycle_count;
    thermostat_scoreboard scoreboard = new();

    thermostat_deadband_controller DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_external_code    (s_external_code),
        .s_internal_code    (s_internal_code),
        .s_button_up        (s_button_up),
        .s_button_down      (s_button_down),
        .s_button_mode      (s_button_mode),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_furnace_on       (m_furnace_on),
        .m_external_tenths  (m_external_tenths),
        .m_internal_tenths  (m_internal_tenths),
        .m_setpoint_degrees (m_setpoint_degrees),
        .m_using_internal   (m_using_internal),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested
    initial begin : receiver
        int holds_done;
        holds_done = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_requests != holds_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds_done++;
            end
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                scoreboard.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready)
                scoreboard.predict_tick(s_external_code, s_internal_code,
                                        s_button_up, s_button_down, s_button_mode);
            if (m_valid === 1'b1 && m_ready)
                scoreboard.check_tick({m_furnace_on, m_external_tenths, m_internal_tenths,
                                       m_setpoint_degrees, m_using_internal});
        end
    end

    task automatic send_tick(input logic [CODE_W-1:0] ext_code,
                             input logic [CODE_W-1:0] int_code,
                             input logic up, input logic down, input logic mode);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_valid         <= 1'b1;
        s_external_code <= ext_code;
        s_internal_code <= int_code;
        s_button_up     <= up;
        s_button_down   <= down;
        s_button_mode   <= mode;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [CODE_W-1:0] clamp_code(longint v);
        if (v < 0) return '0;
        if (v > 1023) return '1;
        return CODE_W'(v);
    endfunction

    // Mostly readings close to the dead band so the furnace holds and flips often
    task automatic send_random_ticks(input int count);
        logic [CODE_W-1:0] ext_code;
        logic [CODE_W-1:0] int_code;
        longint            target;
        longint            span;
        int unsigned       pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            span = longint'(scoreboard.half_band) + 6;
            target = longint'(scoreboard.setpoint) * 10 - span
                     + longint'($urandom_range(0, 2 * int'(span)));
            if (pick < 15) begin
                ext_code = CODE_W'($urandom);
                int_code = CODE_W'($urandom);
            end else if (pick < 25) begin
                ext_code = $urandom_range(1) ? '1 : '0;
                int_code = $urandom_range(1) ? '1 : '0;
            end else begin
                ext_code = clamp_code((target * 128) / 625 + longint'($urandom_range(2)) - 1);
                if (scoreboard.gain != 0)
                    int_code = clamp_code((target * 65536 + longint'(scoreboard.offset))
                                          / longint'(scoreboard.gain)
                                          + longint'($urandom_range(2)) - 1);
                else
                    int_code = CODE_W'($urandom);
            end
            send_tick(ext_code, int_code, $urandom_range(99) < 15, $urandom_range(99) < 15,
                      $urandom_range(99) < 10);
        end
    endtask

    // Drop valid and wait until every result item has come back
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (scoreboard.pending() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_regs(input logic [CFG_DATA_W-1:0] gain_word,
                            input logic [CFG_DATA_W-1:0] offset_word,
                            input logic [CFG_DATA_W-1:0] band_word);
        write_reg(CFG_UNUSED, '1);
        write_reg(CFG_GAIN, gain_word);
        write_reg(CFG_OFFSET, offset_word);
        write_reg(CFG_HALF_BAND, band_word);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_external_code = '0;
        s_internal_code = '0;
        s_button_up     = 1'b0;
        s_button_down   = 1'b0;
        s_button_mode   = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed ticks at reset settings: code extremes, dead band, setpoint wrap
        send_tick(10'd0, 10'd0, 1'b0, 1'b0, 1'b0);
        send_tick(10'd1023, 10'd1023, 1'b0, 1'b0, 1'b0);
        send_tick(10'd47, 10'd512, 1'b0, 1'b0, 1'b0);
        send_tick(10'd0, 10'd1023, 1'b0, 1'b0, 1'b0);
        send_tick(10'd47, 10'd0, 1'b0, 1'b0, 1'b0);
        for (int i = 0; i < 12; i++)
            send_tick(CODE_W'(i * 93), CODE_W'(1023 - i * 93), 1'b1, 1'b0, 1'b0);
        send_tick(10'd1023, 10'd300, 1'b1, 1'b0, 1'b0);
        send_tick(10'd0, 10'd700, 1'b0, 1'b1, 1'b0);
        send_tick(10'd682, 10'd341, 1'b1, 1'b1, 1'b0);
        send_tick(10'd341, 10'd0, 1'b1, 1'b0, 1'b1);
        send_tick(10'd0, 10'd1023, 1'b1, 1'b1, 1'b0);
        send_tick(10'd47, 10'd512, 1'b0, 1'b0, 1'b1);
        send_random_ticks(100);
        drain();

        // Gain at full scale, zero offset, zero band; upper bits of the data ignored
        set_regs(31'h7FFFFFFF, 31'd0, 31'h7FFFFF00);
        sender_idle_pct = 63;
        send_random_ticks(120);
        drain();

        // Zero gain, largest offset, widest band
        set_regs(31'h7F000000, 31'h7FFFFFFF, 31'd255);
        sender_idle_pct = 0;
        receiver_stall_pct = 63;
        send_random_ticks(120);
        drain();

        set_regs(CFG_DATA_W'($urandom_range(2000000)), CFG_DATA_W'($urandom),
                 CFG_DATA_W'($urandom_range(40)));
        sender_idle_pct = 29;
        receiver_stall_pct = 29;
        send_random_ticks(130);
        drain();

        // Back to reset values; hold the result side off so the pipeline fills
        set_regs(CFG_DATA_W'(GAIN_RESET), CFG_DATA_W'(OFFSET_RESET),
                 CFG_DATA_W'(BAND_RESET));
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_requests++;
        send_random_ticks(130);
        drain();

        set_regs(CFG_DATA_W'($urandom_range(1200000, 700000)),
                 CFG_DATA_W'($urandom_range(400000000, 200000000)),
                 CFG_DATA_W'($urandom_range(20)));
        sender_idle_pct = 29;
        receiver_stall_pct = 29;
        send_random_ticks(130);
        drain();

        repeat (10) @(posedge aclk);
        if (scoreboard.errors == 0 && scoreboard.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
